>>> rtl/link_delay_loss_emulator_defines.svh
// ----------------------------------------------------------------------------
// Link delay and loss emulator: assertion macros
// Concurrent assertion helpers, compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINK_DELAY_LOSS_EMULATOR_DEFINES_SVH
`define LINK_DELAY_LOSS_EMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define LDE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition in one cycle brings a consequence in the next.
`define LDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LDE_ASSERT(label, clk, rst, prop, msg)
`define LDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/lde_pkg.sv
// ----------------------------------------------------------------------------
// Link delay and loss emulator package
// Field widths, command, event and register codes, and beat structs.
// ----------------------------------------------------------------------------
package lde_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 64;

   localparam int CMD_W   = 2;
   localparam int IDX_W   = 4;
   localparam int IP_W    = 32;
   localparam int PORT_W  = 16;
   localparam int DELAY_W = 16;
   localparam int PCT_W   = 7;
   localparam int TAG_W   = 16;
   localparam int EV_W    = 4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [EV_W-1:0] EV_LOADED        = 4'd0;
   localparam logic [EV_W-1:0] EV_DUPLICATE     = 4'd1;
   localparam logic [EV_W-1:0] EV_CIRCULAR      = 4'd2;
   localparam logic [EV_W-1:0] EV_QUEUED        = 4'd3;
   localparam logic [EV_W-1:0] EV_NO_ROUTE      = 4'd4;
   localparam logic [EV_W-1:0] EV_FULL          = 4'd5;
   localparam logic [EV_W-1:0] EV_FORWARDED     = 4'd6;
   localparam logic [EV_W-1:0] EV_LOST          = 4'd7;
   localparam logic [EV_W-1:0] EV_DELAY_STARTED = 4'd8;
   localparam logic [EV_W-1:0] EV_IDLE          = 4'd9;

   localparam logic [1:0] REG_OWN_IP      = 2'd0;
   localparam logic [1:0] REG_OWN_PORT    = 2'd1;
   localparam logic [1:0] REG_QUEUE_LIMIT = 2'd2;

   localparam logic [PCT_W-1:0] QUEUE_LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [IDX_W-1:0]   entry_index;
      logic [IP_W-1:0]    dest_ip;
      logic [PORT_W-1:0]  dest_port;
      logic [IP_W-1:0]    next_ip;
      logic [PORT_W-1:0]  next_port;
      logic [DELAY_W-1:0] delay_ms;
      logic [PCT_W-1:0]   loss_percent;
      logic [TAG_W-1:0]   packet_tag;
      logic [PCT_W-1:0]   roll;
   } req_type;

   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [TAG_W-1:0]  out_tag;
      logic [IP_W-1:0]   hop_ip;
      logic [PORT_W-1:0] hop_port;
   } rsp_type;

endpackage

>>> rtl/lde_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module lde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/link_delay_loss_emulator.sv
// ----------------------------------------------------------------------------
// Link delay and loss emulator
// Forwarding table, packet tag queue and millisecond delay/loss engine.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   beat taken when
//   -------   -------------------------------------   ------------------------------
//   request   start, busy, req_data                   start high and busy low
//   result    rsp_valid, rsp_data                     rsp_valid high (one cycle only)
//   config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite, pready
//             prdata, pready
//
// Each request beat gives exactly one result beat: the beat passes through the
// input register and then the result register, which drives rsp_valid. busy
// never rises; the table is compared in parallel and the queue head is
// prefetched, so one beat a cycle holds.
// The result side cannot stall: each result is shown for one cycle only.
// reset is synchronous and clears the valid bits, pointers, engine and registers.
// ----------------------------------------------------------------------------
`include "link_delay_loss_emulator_defines.svh"

module link_delay_loss_emulator #(
   parameter int TABLE_ENTRIES = lde_pkg::TABLE_ENTRIES_DEF,
   parameter int QUEUE_DEPTH   = lde_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  lde_pkg::req_type                    req_data,
   // result channel
   output logic                                rsp_valid,
   output lde_pkg::rsp_type                    rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lde_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lde_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lde_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int LIM_W   = (CNT_W > lde_pkg::PCT_W) ? CNT_W : lde_pkg::PCT_W;
   localparam int QWORD_W = SLOT_W + lde_pkg::TAG_W;

   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [lde_pkg::IP_W-1:0]   own_ip_ff;
   logic [lde_pkg::PORT_W-1:0] own_port_ff;
   logic [lde_pkg::PCT_W-1:0]  queue_limit_ff;
   logic                       csr_write;
   logic [1:0]                 csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // Registers sit on word addresses; the low two address bits are ignored.
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff      <= '0;
         own_port_ff    <= '0;
         queue_limit_ff <= lde_pkg::QUEUE_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lde_pkg::REG_OWN_IP:      own_ip_ff      <= pwdata[lde_pkg::IP_W-1:0];
            lde_pkg::REG_OWN_PORT:    own_port_ff    <= pwdata[lde_pkg::PORT_W-1:0];
            lde_pkg::REG_QUEUE_LIMIT: queue_limit_ff <= pwdata[lde_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lde_pkg::REG_OWN_IP:      prdata = own_ip_ff;
         lde_pkg::REG_OWN_PORT:
            prdata = {{(lde_pkg::CSR_DATA_W - lde_pkg::PORT_W){1'b0}}, own_port_ff};
         lde_pkg::REG_QUEUE_LIMIT:
            prdata = {{(lde_pkg::CSR_DATA_W - lde_pkg::PCT_W){1'b0}}, queue_limit_ff};
         default:                  prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Input register: hold each accepted beat for processing
   // ------------------------------------------------------------------------
   logic             item_valid_ff;
   lde_pkg::req_type item_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         item_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------------
   // Forwarding table: valid bits reset, payload written by load beats only
   // ------------------------------------------------------------------------
   logic                         entry_valid_ff     [TABLE_ENTRIES];
   logic [lde_pkg::IP_W-1:0]     entry_dest_ip_ff   [TABLE_ENTRIES];
   logic [lde_pkg::PORT_W-1:0]   entry_dest_port_ff [TABLE_ENTRIES];
   logic [lde_pkg::IP_W-1:0]     entry_hop_ip_ff    [TABLE_ENTRIES];
   logic [lde_pkg::PORT_W-1:0]   entry_hop_port_ff  [TABLE_ENTRIES];
   logic [lde_pkg::DELAY_W-1:0]  entry_delay_ff     [TABLE_ENTRIES];
   logic [lde_pkg::PCT_W-1:0]    entry_loss_ff      [TABLE_ENTRIES];

   logic                         tbl_we;
   logic [SLOT_W-1:0]            slot;
   logic [TABLE_ENTRIES-1:0]     match;
   logic                         dup;
   logic                         circ;
   logic                         hit;
   logic [SLOT_W-1:0]            hit_slot;

   // Fold entry_index onto the table: a sixteen-way constant lookup.
   always_comb begin
      slot = '0;
      for (int v = 0; v < (1 << lde_pkg::IDX_W); v++) begin
         if (item_ff.entry_index == lde_pkg::IDX_W'(v)) begin
            slot = SLOT_W'(v % TABLE_ENTRIES);
         end
      end
   end

   // Compare every slot against the destination at once.
   always_comb begin
      dup      = 1'b0;
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i] = entry_valid_ff[i] && (entry_dest_ip_ff[i] == item_ff.dest_ip)
                    && (entry_dest_port_ff[i] == item_ff.dest_port);
         if (match[i] && (SLOT_W'(i) != slot)) begin
            dup = 1'b1;
         end
      end
      // Lowest matching slot wins.
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   assign circ = (item_ff.next_ip == own_ip_ff) && (item_ff.next_port == own_port_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (tbl_we) begin
         entry_valid_ff[slot] <= 1'b1;
      end
      if (tbl_we) begin
         entry_dest_ip_ff[slot]   <= item_ff.dest_ip;
         entry_dest_port_ff[slot] <= item_ff.dest_port;
         entry_hop_ip_ff[slot]    <= item_ff.next_ip;
         entry_hop_port_ff[slot]  <= item_ff.next_port;
         entry_delay_ff[slot]     <= item_ff.delay_ms;
         entry_loss_ff[slot]      <= item_ff.loss_percent;
      end
   end

   // ------------------------------------------------------------------------
   // Packet queue: tag and route in RAM, pointers and count in flops
   // ------------------------------------------------------------------------
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ram_we;
   logic [QWORD_W-1:0] ram_wdata;
   logic [QWORD_W-1:0] ram_rdata;
   logic               bypass_ff;
   logic [QWORD_W-1:0] bypass_data_ff;
   logic [QWORD_W-1:0] front;
   logic [lde_pkg::TAG_W-1:0] front_tag;
   logic [SLOT_W-1:0]  front_route;
   logic               full;

   assign ram_wdata = {hit_slot, item_ff.packet_tag};

   // The RAM always reads the next head place, so the front entry is ready
   // the cycle after a pop. A write into that same place is forwarded.
   lde_ram #(
      .WIDTH (QWORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_addr (head_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= ram_we && (tail_ff == head_in);
      end
      bypass_data_ff <= ram_wdata;
   end

   assign front       = bypass_ff ? bypass_data_ff : ram_rdata;
   assign front_tag   = front[lde_pkg::TAG_W-1:0];
   assign front_route = front[QWORD_W-1:lde_pkg::TAG_W];

   // Full at the programmed limit or at the physical depth, whichever first.
   assign full = (LIM_W'(count_ff) >= LIM_W'(queue_limit_ff)) || (count_ff >= DEPTH_CNT);

   // ------------------------------------------------------------------------
   // Delay engine and result selection
   // ------------------------------------------------------------------------
   logic                         delaying_ff, delaying_in;
   logic [lde_pkg::DELAY_W-1:0]  remaining_ff, remaining_in;
   logic                         rsp_valid_ff;
   lde_pkg::rsp_type             rsp_ff, rsp_in;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      delaying_in  = delaying_ff;
      remaining_in = remaining_ff;
      tbl_we       = 1'b0;
      ram_we       = 1'b0;
      rsp_in       = '{event_res: lde_pkg::EV_IDLE, out_tag: '0, hop_ip: '0, hop_port: '0};
      if (item_valid_ff) begin
         case (item_ff.cmd)
            lde_pkg::CMD_LOAD: begin
               // Duplicate destination takes precedence over a circular hop.
               if (dup) begin
                  rsp_in.event_res = lde_pkg::EV_DUPLICATE;
               end else if (circ) begin
                  rsp_in.event_res = lde_pkg::EV_CIRCULAR;
               end else begin
                  tbl_we           = 1'b1;
                  rsp_in.event_res = lde_pkg::EV_LOADED;
               end
            end
            lde_pkg::CMD_ARRIVE: begin
               rsp_in.out_tag = item_ff.packet_tag;
               if (full) begin
                  rsp_in.event_res = lde_pkg::EV_FULL;
               end else if (!hit) begin
                  rsp_in.event_res = lde_pkg::EV_NO_ROUTE;
               end else begin
                  ram_we           = 1'b1;
                  tail_in          = (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_W'(1);
                  count_in         = count_ff + CNT_W'(1);
                  rsp_in.event_res = lde_pkg::EV_QUEUED;
               end
            end
            lde_pkg::CMD_TICK: begin
               if (delaying_ff && (count_ff != '0)) begin
                  if (remaining_ff != '0) begin
                     // Count the delay down; answer idle.
                     remaining_in = remaining_ff - lde_pkg::DELAY_W'(1);
                  end else begin
                     // Delay spent: pop the front packet and roll for loss.
                     head_in        = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
                     count_in       = count_ff - CNT_W'(1);
                     delaying_in    = 1'b0;
                     rsp_in.out_tag = front_tag;
                     if (item_ff.roll >= entry_loss_ff[front_route]) begin
                        rsp_in.event_res = lde_pkg::EV_FORWARDED;
                        rsp_in.hop_ip    = entry_hop_ip_ff[front_route];
                        rsp_in.hop_port  = entry_hop_port_ff[front_route];
                     end else begin
                        rsp_in.event_res = lde_pkg::EV_LOST;
                     end
                  end
               end else begin
                  // Drop a stale delaying flag, then start the front packet.
                  delaying_in = 1'b0;
                  if (count_ff != '0) begin
                     delaying_in      = 1'b1;
                     remaining_in     = entry_delay_ff[front_route];
                     rsp_in.event_res = lde_pkg::EV_DELAY_STARTED;
                     rsp_in.out_tag   = front_tag;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         delaying_ff  <= 1'b0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         delaying_ff  <= delaying_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= item_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   logic queue_empty;
   logic empty_ptrs_ok;
   logic resolve_shown;

   assign queue_empty   = (count_ff == '0);
   assign empty_ptrs_ok = !queue_empty || (head_ff == tail_ff);
   assign resolve_shown = rsp_valid_ff && ((rsp_ff.event_res == lde_pkg::EV_FORWARDED)
                                           || (rsp_ff.event_res == lde_pkg::EV_LOST));

   `LDE_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_CNT, "queue count above depth")
   `LDE_ASSERT(a_empty_ptrs, clock, reset, empty_ptrs_ok, "pointers apart on an empty queue")
   `LDE_ASSERT_NEXT(a_one_result, clock, reset, item_valid_ff, rsp_valid_ff, "result missing")
   `LDE_ASSERT_NEXT(a_pop_nonempty, clock, reset, queue_empty, !resolve_shown, "pop from empty")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link delay and loss emulator testbench
// Drives a short scripted sequence and then random phases of table loads,
// packet arrivals and millisecond ticks through the command port. Each phase
// runs under its own node address and queue limit, written over the APB-style
// port while the block is idle. Every result beat is checked field by field
// against an in-bench model of the forwarding table, tag queue and delay
// engine, or a pinned row's hand-written result. A watchdog ends a stalled run.
// ----------------------------------------------------------------------------
module testbench;
   import lde_pkg::*;

   // cmd 3 has no meaning: the block must answer idle and change nothing
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int TABLE_SLOTS    = TABLE_ENTRIES_DEF;
   localparam int QUEUE_SLOTS    = QUEUE_DEPTH_DEF;
   localparam int RESULT_LATENCY = 2;
   localparam int STALL_LIMIT    = 200;
   localparam int PHASES         = 5;
   localparam int PHASE_BEATS    = 170;
   localparam int POOL_SIZE      = 8;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      req_type beat;
      logic    pinned;
      rsp_type want;
   } script_row_type;

   // ---------------------------------------------------------------------
   // DUT connections
   // ---------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Scripted rows carry a hand-written result alongside the beat
   logic                  want_pinned;
   rsp_type               want_event;

   link_delay_loss_emulator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // ---------------------------------------------------------------------
   // Model state: node configuration, forwarding table, tag queue, engine
   // ---------------------------------------------------------------------
   logic [IP_W-1:0]    cfg_own_ip      = '0;
   logic [PORT_W-1:0]  cfg_own_port    = '0;
   logic [PCT_W-1:0]   cfg_queue_limit = QUEUE_LIMIT_RESET;

   bit                 route_valid   [TABLE_SLOTS];
   logic [IP_W-1:0]    route_dest_ip [TABLE_SLOTS];
   logic [PORT_W-1:0]  route_dest_pt [TABLE_SLOTS];
   logic [IP_W-1:0]    route_hop_ip  [TABLE_SLOTS];
   logic [PORT_W-1:0]  route_hop_pt  [TABLE_SLOTS];
   logic [DELAY_W-1:0] route_delay   [TABLE_SLOTS];
   logic [PCT_W-1:0]   route_loss    [TABLE_SLOTS];

   logic [TAG_W-1:0]   held_tag   [QUEUE_SLOTS];
   int                 held_route [QUEUE_SLOTS];
   int                 held_head  = 0;
   int                 held_tail  = 0;
   int                 held_count = 0;
   bit                 in_delay   = 1'b0;
   logic [DELAY_W-1:0] hold_left  = '0;

   rsp_type            pending_events [$];
   int                 fault_count  = 0;
   int                 stall_cycles = 0;
   int                 burst_left   = 0;

   // Destinations that loads and arrivals draw from, so that routes match
   logic [IP_W-1:0]    pool_ip   [POOL_SIZE];
   logic [PORT_W-1:0]  pool_port [POOL_SIZE];

   script_row_type     script [$];

   // Advance the model by one command beat and return the event it causes
   function automatic rsp_type emulate_link(req_type b);
      rsp_type ev;
      int      i;
      int      slot;
      int      found;
      ev = '0;
      ev.event_res = EV_IDLE;
      found = -1;
      case (b.cmd)
         CMD_LOAD: begin
            slot = b.entry_index;
            for (i = 0; i < TABLE_SLOTS; i++)
               if (i != slot && route_valid[i] && route_dest_ip[i] == b.dest_ip &&
                   route_dest_pt[i] == b.dest_port)
                  found = i;
            if (found >= 0)
               ev.event_res = EV_DUPLICATE;
            else if (b.next_ip == cfg_own_ip && b.next_port == cfg_own_port)
               ev.event_res = EV_CIRCULAR;
            else begin
               route_valid[slot]   = 1'b1;
               route_dest_ip[slot] = b.dest_ip;
               route_dest_pt[slot] = b.dest_port;
               route_hop_ip[slot]  = b.next_ip;
               route_hop_pt[slot]  = b.next_port;
               route_delay[slot]   = b.delay_ms;
               route_loss[slot]    = b.loss_percent;
               ev.event_res        = EV_LOADED;
            end
         end
         CMD_ARRIVE: begin
            ev.out_tag = b.packet_tag;
            if (held_count >= cfg_queue_limit || held_count >= QUEUE_SLOTS)
               ev.event_res = EV_FULL;
            else begin
               for (i = 0; i < TABLE_SLOTS; i++)
                  if (found < 0 && route_valid[i] && route_dest_ip[i] == b.dest_ip &&
                      route_dest_pt[i] == b.dest_port)
                     found = i;
               if (found < 0)
                  ev.event_res = EV_NO_ROUTE;
               else begin
                  held_tag[held_tail]   = b.packet_tag;
                  held_route[held_tail] = found;
                  held_tail             = (held_tail + 1) % QUEUE_SLOTS;
                  held_count++;
                  ev.event_res          = EV_QUEUED;
               end
            end
         end
         CMD_TICK: begin
            if (in_delay && held_count == 0)
               in_delay = 1'b0;
            if (in_delay) begin
               if (hold_left != 0)
                  hold_left--;
               else begin
                  slot       = held_route[held_head];
                  ev.out_tag = held_tag[held_head];
                  held_head  = (held_head + 1) % QUEUE_SLOTS;
                  held_count--;
                  in_delay   = 1'b0;
                  if (b.roll >= route_loss[slot]) begin
                     ev.event_res = EV_FORWARDED;
                     ev.hop_ip    = route_hop_ip[slot];
                     ev.hop_port  = route_hop_pt[slot];
                  end else
                     ev.event_res = EV_LOST;
               end
            end else if (held_count != 0) begin
               slot         = held_route[held_head];
               hold_left    = route_delay[slot];
               in_delay     = 1'b1;
               ev.event_res = EV_DELAY_STARTED;
               ev.out_tag   = held_tag[held_head];
            end
         end
         default: ;
      endcase
      return ev;
   endfunction

   function automatic req_type mk_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                      logic [IP_W-1:0] dip, logic [PORT_W-1:0] dport,
                                      logic [IP_W-1:0] nip, logic [PORT_W-1:0] nport,
                                      logic [DELAY_W-1:0] dly, logic [PCT_W-1:0] loss,
                                      logic [TAG_W-1:0] tag, logic [PCT_W-1:0] roll);
      req_type b;
      b.cmd          = cmd;
      b.entry_index  = idx;
      b.dest_ip      = dip;
      b.dest_port    = dport;
      b.next_ip      = nip;
      b.next_port    = nport;
      b.delay_ms     = dly;
      b.loss_percent = loss;
      b.packet_tag   = tag;
      b.roll         = roll;
      return b;
   endfunction

   function automatic rsp_type mk_rsp(logic [EV_W-1:0] ev, logic [TAG_W-1:0] tag,
                                      logic [IP_W-1:0] hip, logic [PORT_W-1:0] hport);
      rsp_type r;
      r.event_res = ev;
      r.out_tag   = tag;
      r.hop_ip    = hip;
      r.hop_port  = hport;
      return r;
   endfunction

   // Random command beat: mostly well-formed traffic on the pool's routes,
   // with some noise, circular hops and out-of-range percentages mixed in
   function automatic req_type draw_item();
      req_type b;
      int      pick;
      int      kind;
      pick = $urandom_range(0, POOL_SIZE - 1);
      kind = $urandom_range(0, 99);
      b.entry_index  = IDX_W'($urandom);
      b.dest_ip      = $urandom;
      b.dest_port    = PORT_W'($urandom);
      b.next_ip      = $urandom;
      b.next_port    = PORT_W'($urandom);
      b.delay_ms     = ($urandom_range(0, 15) == 0) ? DELAY_W'($urandom_range(4, 20))
                                                    : DELAY_W'($urandom_range(0, 3));
      b.loss_percent = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(0, 127))
                                                   : PCT_W'($urandom_range(0, 100));
      b.packet_tag   = TAG_W'($urandom);
      b.roll         = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(0, 127))
                                                   : PCT_W'($urandom_range(0, 100));
      if (kind < 15) begin
         b.cmd = CMD_LOAD;
         if ($urandom_range(0, 3) != 0) begin
            b.dest_ip   = pool_ip[pick];
            b.dest_port = pool_port[pick];
         end
         if ($urandom_range(0, 9) == 0) begin
            b.next_ip   = cfg_own_ip;
            b.next_port = cfg_own_port;
         end
      end else if (kind < 55) begin
         b.cmd = CMD_ARRIVE;
         if ($urandom_range(0, 99) < 85) begin
            b.dest_ip   = pool_ip[pick];
            b.dest_port = pool_port[pick];
         end
      end else if (kind < 96)
         b.cmd = CMD_TICK;
      else
         b.cmd = CMD_UNUSED;
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Check result beats and record the expectation of each accepted beat.
   // Check before recording: a result never answers the beat of its own edge.
   // ---------------------------------------------------------------------
   task automatic record_fault(string what, rsp_type want, rsp_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t %s: expected ev %0d tag %h hop %h:%h, got ev %0d tag %h hop %h:%h",
                  $realtime, what, want.event_res, want.out_tag, want.hop_ip, want.hop_port,
                  got.event_res, got.out_tag, got.hop_ip, got.hop_port);
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type oldest;
      rsp_type fresh;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_events.size() == 0)
               record_fault("unexpected result", '0, rsp_data);
            else begin
               oldest = pending_events.pop_front();
               if (rsp_data.event_res !== oldest.event_res ||
                   rsp_data.out_tag   !== oldest.out_tag   ||
                   rsp_data.hop_ip    !== oldest.hop_ip    ||
                   rsp_data.hop_port  !== oldest.hop_port)
                  record_fault("result differs", oldest, rsp_data);
            end
         end
         if (start && !busy) begin
            // run the model on every beat so that its state tracks the block
            fresh = emulate_link(req_data);
            if (want_pinned)
               fresh = want_event;
            pending_events.push_back(fresh);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run after too many cycles without any beat moving
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         stall_cycles <= 0;
      else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("link_delay_loss_emulator: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Offer one command beat and hold it until taken; open a gap between
   // bursts, some bursts long enough to run with no idling at all
   task automatic offer(req_type b, logic pinned, rsp_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start       <= 1'b1;
      req_data    <= b;
      want_pinned <= pinned;
      want_event  <= want;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, let every expected result arrive, then let the pipeline empty
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   // Setup phase, access phase, then an idle phase before the next write
   task automatic csr_write(logic [1:0] which, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_OWN_IP:      cfg_own_ip      = value[IP_W-1:0];
         REG_OWN_PORT:    cfg_own_port    = value[PORT_W-1:0];
         REG_QUEUE_LIMIT: cfg_queue_limit = value[PCT_W-1:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      want_pinned <= 1'b0;
      want_event  <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;

      // Scripted part, run at the reset configuration (node 0:0, limit 64)
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(EV_IDLE, 0, 0, 0)});
      // unused command with every field at its top value
      script.push_back('{mk_req(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1,
                         mk_rsp(EV_IDLE, 0, 0, 0)});
      script.push_back('{mk_req(CMD_ARRIVE, 0, '1, '1, 0, 0, 0, 0, 16'hFFFF, 0), 1'b1,
                         mk_rsp(EV_NO_ROUTE, 16'hFFFF, 0, 0)});
      // next hop equal to the node itself
      script.push_back('{mk_req(CMD_LOAD, 0, 32'hC0A8_0001, 16'd80, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(EV_CIRCULAR, 0, 0, 0)});
      script.push_back('{mk_req(CMD_LOAD, 0, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd9000,
                                0, 0, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_LOAD, 15, '1, '1, '1, '1, 16'd2, 7'd100, 0, 0), 1'b1,
                         mk_rsp(EV_LOADED, 0, 0, 0)});
      // same destination in another slot
      script.push_back('{mk_req(CMD_LOAD, 3, 32'hC0A8_0001, 16'd80, 32'h1, 16'h1, 0, 0, 0, 0),
                         1'b1, mk_rsp(EV_DUPLICATE, 0, 0, 0)});
      // rewrite of the same slot is an update
      script.push_back('{mk_req(CMD_LOAD, 0, 32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'd9001,
                                16'd1, 7'd50, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_ARRIVE, 0, 32'hC0A8_0001, 16'd80, 0, 0, 0, 0, 16'h0001, 0),
                         1'b0, '0});
      script.push_back('{mk_req(CMD_ARRIVE, 0, '1, '1, 0, 0, 0, 0, 16'hFFFF, 0), 1'b1,
                         mk_rsp(EV_QUEUED, 16'hFFFF, 0, 0)});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      // roll equal to the loss percent forwards
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 7'd50), 1'b1,
                         mk_rsp(EV_FORWARDED, 16'h0001, 32'h0A00_0002, 16'd9001)});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 7'd99), 1'b1,
                         mk_rsp(EV_LOST, 16'hFFFF, 0, 0)});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      // longest delay, replaced before any packet can use it
      script.push_back('{mk_req(CMD_LOAD, 5, 0, 0, 32'h1, 16'h1, 16'hFFFF, 7'd127, 0, 0), 1'b1,
                         mk_rsp(EV_LOADED, 0, 0, 0)});
      script.push_back('{mk_req(CMD_LOAD, 5, 0, 0, 32'h1, 16'h1, 0, 7'd127, 0, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_ARRIVE, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 0), 1'b0, '0});
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      // loss and roll both above the percent range
      script.push_back('{mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 7'd127), 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[k])
         offer(script[k].beat, script[k].pinned, script[k].want);

      // Random phases, each under a fresh node address and queue limit
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               csr_write(REG_OWN_IP, $urandom);
               csr_write(REG_OWN_PORT, $urandom_range(0, 16'hFFFF));
               csr_write(REG_QUEUE_LIMIT, QUEUE_LIMIT_RESET);
            end
            1: begin
               csr_write(REG_OWN_IP, 32'hFFFF_FFFF);
               csr_write(REG_OWN_PORT, 32'h0000_FFFF);
               csr_write(REG_QUEUE_LIMIT, 1);
            end
            2: begin
               // limit of zero refuses every arrival; queued packets drain
               csr_write(REG_OWN_IP, $urandom);
               csr_write(REG_OWN_PORT, $urandom_range(0, 16'hFFFF));
               csr_write(REG_QUEUE_LIMIT, 0);
            end
            3: begin
               // limit above the queue depth: the depth itself governs
               csr_write(REG_OWN_IP, 0);
               csr_write(REG_OWN_PORT, 0);
               csr_write(REG_QUEUE_LIMIT, 127);
            end
            default: begin
               csr_write(REG_OWN_IP, $urandom);
               csr_write(REG_OWN_PORT, $urandom_range(0, 16'hFFFF));
               csr_write(REG_QUEUE_LIMIT, $urandom_range(2, 12));
            end
         endcase
         for (int k = 0; k < POOL_SIZE; k++) begin
            pool_ip[k]   = $urandom;
            pool_port[k] = PORT_W'($urandom);
         end
         repeat (PHASE_BEATS) offer(draw_item(), 1'b0, '0);
      end

      settle();
      if (fault_count == 0 && pending_events.size() == 0)
         $display("link_delay_loss_emulator: match");
      else
         $display("link_delay_loss_emulator: mismatch");
      $finish;
   end

endmodule
